// File: hw/rtl/iir_pkg.sv
// Shared types and constants for the direct-form I IIR filter.
package iir_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 20;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = PROD_W + 4;
	localparam int FRAC_W    = 16;
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = 3;
	// Wide enough for the term counter of the highest supported order.
	localparam int STEP_W    = 3;

	localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd4;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef struct packed {
		logic              load;
		logic              clear;
		logic              mac;
		logic [STEP_W-1:0] step;
		logic              fin;
	} iir_cmd_t;

endpackage

// File: hw/rtl/iir_if.sv
// Valid/ready channel interfaces for samples, results and coefficient writes.
interface iir_in_if
	import iir_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_in;
	logic    block_start;

	modport source (output valid, output sample_in, output block_start, input ready);
	modport sink (input valid, input sample_in, input block_start, output ready);
endinterface

interface iir_out_if
	import iir_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface iir_cfg_if
	import iir_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	coef_t                data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/iir_ctrl.sv
// Sequencer that steps the shared multiply-accumulate through all filter terms.
module iir_ctrl
	import iir_pkg::*;
#(
	parameter int FILTER_ORDER = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_block_start,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output iir_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * FILTER_ORDER);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              fin_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// The result register may be refilled in the cycle its old value is taken.
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load  = in_valid && in_ready;
		cmd.clear = in_valid && in_ready && in_block_start;
		cmd.mac   = (state_q == ST_MAC);
		cmd.step  = step_q;
		cmd.fin   = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MAC;
						step_q  <= '0;
					end
				end
				ST_MAC: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/iir_dpath.sv
// Coefficient registers, sample histories, shared multiplier and accumulator.
module iir_dpath
	import iir_pkg::*;
#(
	parameter int FILTER_ORDER = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iir_cmd_t             cmd,
	input  sample_t              sample_in,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  coef_t                cfg_data,
	output sample_t              sample_out,
	output logic                 saturated
);

	localparam int HIST_IDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

	coef_t   coef_q [NUM_REGS];
	sample_t xh_q   [FILTER_ORDER];
	sample_t yh_q   [FILTER_ORDER];
	sample_t x_q;
	acc_t    acc_q;
	prod_t   prod_s1;
	logic    sub_s1;
	logic    valid_s1;
	sample_t out_q;
	logic    sat_q;

	logic [STEP_W-1:0]     step_m1;
	logic [HIST_IDX_W-1:0] hidx;
	logic [REG_IDX_W-1:0]  cidx;
	logic                  is_fb;
	coef_t                 mul_c;
	sample_t               mul_x;
	acc_t                  rnd_sum;
	logic signed [ACC_W-FRAC_W-1:0] rnd_q;
	sample_t               r_sat;
	logic                  r_clip;

	// Step 0 is b0*x; odd steps take bk*x[n-k], even steps take ak*y[n-k].
	always_comb begin
		step_m1 = cmd.step - 1'b1;
		hidx    = HIST_IDX_W'(step_m1 >> 1);
		is_fb   = (cmd.step != '0) && !cmd.step[0];
		if (cmd.step == '0) begin
			cidx  = REG_B0;
			mul_x = x_q;
		end else if (is_fb) begin
			cidx  = REG_A1 + REG_IDX_W'(hidx);
			mul_x = yh_q[hidx];
		end else begin
			cidx  = REG_B1 + REG_IDX_W'(hidx);
			mul_x = xh_q[hidx];
		end
		mul_c = coef_q[cidx];
	end

	// Round half up, then clip to the sample range.
	always_comb begin
		rnd_sum = acc_q + ACC_W'(signed'(32768));
		rnd_q   = rnd_sum[ACC_W-1:FRAC_W];
		if (rnd_q > (ACC_W-FRAC_W)'(signed'(32767))) begin
			r_sat  = 16'sh7fff;
			r_clip = 1'b1;
		end else if (rnd_q < (ACC_W-FRAC_W)'(signed'(-32768))) begin
			r_sat  = 16'sh8000;
			r_clip = 1'b1;
		end else begin
			r_sat  = rnd_q[SAMPLE_W-1:0];
			r_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[REG_B0] <= COEF_ONE;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac;
			if (cmd.clear) begin
				for (int i = 0; i < FILTER_ORDER; i++) begin
					xh_q[i] <= '0;
					yh_q[i] <= '0;
				end
			end else if (cmd.fin) begin
				for (int i = FILTER_ORDER - 1; i > 0; i--) begin
					xh_q[i] <= xh_q[i-1];
					yh_q[i] <= yh_q[i-1];
				end
				xh_q[0] <= x_q;
				yh_q[0] <= r_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= sample_in;
		end
		prod_s1 <= mul_c * mul_x;
		sub_s1  <= is_fb;
		if (cmd.load) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
		if (cmd.fin) begin
			out_q <= r_sat;
			sat_q <= r_clip;
		end
	end

	assign sample_out = out_q;
	assign saturated  = sat_q;

endmodule

// File: hw/rtl/iir_filter_direct_form_one.sv
// Top level of the direct-form I IIR filter with a shared multiply-accumulate.
//
// Samples arrive on in_ch (sample_in, block_start) and filtered samples leave
// on out_ch (sample_out, saturated); both use valid/ready, and a request moves
// at a clock edge where both are high. Coefficients are written on cfg_ch by
// register index (b0..b3, a1..a3); the port is always ready and writes to an
// index beyond the list are dropped. Write coefficients only while idle.
// Each accepted sample steps through the MAC state, one term per cycle through
// the single multiplier, then a drain state that empties the product register,
// and a final state that rounds and clips the sum into the output register.
// A new sample is accepted only after the previous result is registered, as
// in_ready is high only while the sequencer is idle.
// A result waits in its output register while the receiver stalls; the next
// sample is still taken and worked on, and only the final write-back waits.
// Reset loads b0 = 1.0 and the other coefficients as zero, and clears both
// sample histories; block_start clears them before its own sample.
module iir_filter_direct_form_one
	import iir_pkg::*;
#(
	parameter int FILTER_ORDER = 3
) (
	input logic    clk,
	input logic    arst_n,
	iir_in_if.sink   in_ch,
	iir_out_if.source out_ch,
	iir_cfg_if.sink  cfg_ch
);

	iir_cmd_t cmd;
	logic     cfg_we;

	assign cfg_ch.ready = 1'b1;
	assign cfg_we = cfg_ch.valid && (cfg_ch.index < REG_IDX_W'(NUM_REGS));

	iir_ctrl #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_block_start(in_ch.block_start),
		.in_ready      (in_ch.ready),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.cmd           (cmd)
	);

	iir_dpath #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample_in (in_ch.sample_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.sample_out(out_ch.sample_out),
		.saturated (out_ch.saturated)
	);

endmodule
